// ===== hdl/dctl_pkg.sv =====
// Package for the duty-cycle transmit limiter.
// Holds item types, kind codes, register indexes and sizing constants.
// No dependencies.
package dctl_pkg;

    // Default store depth
    localparam int STACK_DEPTH_DEF = 32;

    // Register file
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_FACTOR      = 2'd1;

    localparam logic [31:0] INITIAL_INTERVAL_RST = 32'd10000;
    localparam logic [7:0]  DUTY_FACTOR_RST      = 8'd100;

    // Item kinds
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  dest_address;
        logic [7:0]  payload_byte;
        logic [23:0] airtime_ms;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] send_address;
        logic [7:0] send_payload;
    } t_out_item;

    // One stored message: address in the high byte
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
    } t_msg;

    // Stack control from the top level
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    // Stack status
    typedef struct packed {
        logic empty;
        logic full;
    } t_stack_sts;

    // Gate control from the top level
    typedef struct packed {
        logic tick;
        logic finish;
    } t_gate_ctl;

endpackage

// ===== hdl/dctl_stack.sv =====
// Last-in-first-out message store for the duty-cycle transmit limiter.
// Top entry in a register, the rest in a memory with a prefetched entry below.
// Depends on dctl_pkg.
module dctl_stack
    import dctl_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stack_ctl i_ctl,
    input  t_msg       i_msg,
    output t_msg       o_top,
    output t_stack_sts o_sts
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    t_msg           mem [STACK_DEPTH];
    t_msg           r_top, n_top;
    t_msg           r_below;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  cnt_m1, n_cnt_m2;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic           empty, full, do_push, do_pop, mem_we;

    assign empty   = (r_count == '0);
    assign full    = (r_count == CW'(STACK_DEPTH));
    assign do_push = i_ctl.push && !full;
    assign do_pop  = i_ctl.pop && !empty;

    // Old top moves into memory on a push
    assign cnt_m1  = r_count - CW'(1);
    assign wr_addr = cnt_m1[AW-1:0];
    assign mem_we  = do_push && !empty;

    // Next count and top
    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        if (do_push) begin
            n_count = r_count + CW'(1);
            n_top   = i_msg;
        end else if (do_pop) begin
            n_count = cnt_m1;
            n_top   = r_below;
        end
    end

    // Prefetch the entry below the next top
    assign n_cnt_m2 = n_count - CW'(2);
    assign rd_addr  = n_cnt_m2[AW-1:0];

    // Memory write
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_top;
        end
    end

    // Registered read, bypassed on a push (read address equals write address)
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_below <= r_top;
        end else begin
            r_below <= mem[rd_addr];
        end
    end

    // Count and top register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_top <= n_top;
    end

    assign o_top       = r_top;
    assign o_sts.empty = empty;
    assign o_sts.full  = full;

endmodule

// ===== hdl/dctl_gate.sv =====
// Send timing gate for the duty-cycle transmit limiter.
// Millisecond clock, busy flag, send gap and the configuration registers.
// Depends on dctl_pkg.
module dctl_gate
    import dctl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_gate_ctl              i_ctl,
    input  logic [23:0]            i_airtime_ms,
    input  logic                   i_stack_empty,
    output logic                   o_release,
    output logic                   o_busy
);

    logic [31:0] r_now, r_last, r_start, r_gap;
    logic [7:0]  r_factor;
    logic        r_busy;
    logic [31:0] now_inc, since_last, lapse, product;

    // Release decision on a tick
    assign now_inc    = r_now + 32'd1;
    assign since_last = now_inc - r_last;
    assign o_release  = i_ctl.tick && !r_busy && !i_stack_empty && (since_last > r_gap);

    // Airtime limit on a finished transmission (24 x 8 always fits 32 bits)
    assign lapse   = r_now - r_last;
    assign product = {8'd0, i_airtime_ms} * {24'd0, r_factor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= DUTY_FACTOR_RST;
            r_now    <= '0;
            r_last   <= '0;
            r_start  <= '0;
            r_gap    <= INITIAL_INTERVAL_RST;
            r_busy   <= 1'b0;
        end else begin
            // write configuration only while idle (unchecked); the initial interval loads the gap
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INITIAL_INTERVAL: r_gap <= i_cfg_data;
                    CFG_DUTY_FACTOR: r_factor <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_ctl.tick) begin
                r_now <= now_inc;
                if (o_release) begin
                    r_start <= now_inc;
                    r_busy  <= 1'b1;
                end
            end
            if (i_ctl.finish) begin
                r_busy <= 1'b0;
                r_last <= r_start;
                if (product > lapse) begin
                    r_gap <= product;
                end
            end
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== hdl/duty_cycle_tx_limiter.sv =====
// Duty-cycle transmit limiter. Accepts one item per clock with no bubbles unless the
// output stalls; an item is held in the input register, where it is decoded and
// applied to the message store and the timing gate, and a released message is loaded
// into the result register as the tick leaves the input register. The store is read
// from registers (top entry in a register, the entry below prefetched from memory),
// and the 24 x 8 airtime multiply plus 32-bit compare is combinational. The store
// needs no clearing after reset. Configuration is to be written through a plain write
// port only while the block is idle, which the block does not enforce; writing the
// initial interval also reloads the gap.
// Depends on dctl_pkg, dctl_stack, dctl_gate.
module duty_cycle_tx_limiter
    import dctl_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_data
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       advance, fire, release_msg, busy;
    t_stack_ctl stack_ctl;
    t_stack_sts stack_sts;
    t_gate_ctl  gate_ctl;
    t_msg       top, push_msg;

    // Item in the input register moves on when the result slot can take it
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // Decode
    assign gate_ctl.tick   = fire && (r_in.kind == KIND_TICK);
    assign gate_ctl.finish = fire && (r_in.kind == KIND_FINISH);
    assign stack_ctl.push  = fire && (r_in.kind == KIND_PUSH);
    assign stack_ctl.pop   = release_msg;
    assign push_msg.addr   = r_in.dest_address;
    assign push_msg.data   = r_in.payload_byte;

    dctl_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stack_ctl),
        .i_msg   (push_msg),
        .o_top   (top),
        .o_sts   (stack_sts)
    );

    dctl_gate u_gate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ctl         (gate_ctl),
        .i_airtime_ms  (r_in.airtime_ms),
        .i_stack_empty (stack_sts.empty),
        .o_release     (release_msg),
        .o_busy        (busy)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= release_msg;
        end
        if (release_msg) begin
            r_out.send_address <= top.addr;
            r_out.send_payload <= top.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A release always leaves the gate busy
    a_release_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        release_msg |=> busy)
        else $error("release did not set busy");

    // A release only happens on an item that actually moves on
    a_release_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        release_msg |-> fire && !busy && !stack_sts.empty)
        else $error("release without a firing tick");

    // Stall is only raised while an item is held
    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled with nothing held");

    // A new result is only loaded from a tick
    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && release_msg) |-> (r_in.kind == KIND_TICK))
        else $error("result from a non-tick item");

endmodule

// ===== verif/tb_duty_cycle_tx_limiter.sv =====
// Self-checking testbench for duty_cycle_tx_limiter: directed and random items, random
// idling on both channels, and an in-bench model of the transmit gate that predicts each send.
// Depends on dctl_pkg and the duty_cycle_tx_limiter RTL.
`timescale 1ns / 100ps

module tb_duty_cycle_tx_limiter;
    import dctl_pkg::*;

    // Kind code and register indexes the package leaves unnamed
    localparam logic [1:0]             KIND_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int CLK_HALF  = 4;

    // DUT signals; the inputs are all known from time zero
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_data;

    duty_cycle_tx_limiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Gate model state (reset values)
    t_msg        msg_store [STACK_DEPTH_DEF];
    int          msg_count     = 0;
    logic [31:0] clock_ms      = '0;
    logic [31:0] last_start_ms = '0;
    logic [31:0] open_start_ms = '0;
    logic [31:0] hold_off_ms   = INITIAL_INTERVAL_RST;
    logic [7:0]  duty_reg      = DUTY_FACTOR_RST;
    logic        radio_busy    = 1'b0;

    t_in_item  pending_items [$];
    t_out_item expected_sends [$];

    int mismatch_count = 0;
    int release_count  = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    bit send_idle_on   = 1'b1;
    bit recv_stall_on  = 1'b1;

    // Clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Reset: held low from time zero, released once
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Apply one accepted item to the gate model; a released message becomes an expected send
    task automatic gate_predict(input t_in_item it);
        logic [31:0] lapse;
        logic [31:0] product;
        t_out_item   snd;
        case (it.kind)
            KIND_PUSH: begin
                if (msg_count < STACK_DEPTH_DEF) begin
                    msg_store[msg_count] = '{addr: it.dest_address, data: it.payload_byte};
                    msg_count++;
                end
            end
            KIND_TICK: begin
                clock_ms = clock_ms + 32'd1;
                if (!radio_busy && msg_count > 0 && (clock_ms - last_start_ms) > hold_off_ms) begin
                    msg_count--;
                    snd.send_address = msg_store[msg_count].addr;
                    snd.send_payload = msg_store[msg_count].data;
                    expected_sends.push_back(snd);
                    open_start_ms = clock_ms;
                    radio_busy    = 1'b1;
                    release_count++;
                end
            end
            KIND_FINISH: begin
                lapse         = clock_ms - last_start_ms;
                product       = {8'd0, it.airtime_ms} * {24'd0, duty_reg};
                radio_busy    = 1'b0;
                last_start_ms = open_start_ms;
                if (product > lapse)
                    hold_off_ms = product;
            end
            default: ;
        endcase
    endtask

    // Register write; the model follows at the same edge
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_INITIAL_INTERVAL: hold_off_ms = value;
            CFG_DUTY_FACTOR: duty_reg = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Block idle: nothing pending, nothing expected, then a wait for in-flight items
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_sends.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic void queue_item(input logic [1:0] k, input logic [7:0] a,
                                       input logic [7:0] d, input logic [23:0] air);
        t_in_item it;
        it.kind         = k;
        it.dest_address = a;
        it.payload_byte = d;
        it.airtime_ms   = air;
        pending_items.push_back(it);
    endfunction

    // Airtime that keeps the resulting hold-off short
    function automatic logic [23:0] short_airtime();
        if (duty_reg == 8'd0)
            return 24'($urandom_range(0, 255));
        else if (duty_reg >= 8'd40)
            return 24'($urandom_range(0, 1));
        else
            return 24'($urandom_range(0, 40 / duty_reg));
    endfunction

    // Input driver: one item at a time from the pending queue, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid)
                gate_predict(i_in_data);
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_data  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_idle_on = !send_idle_on;
                gap_left = send_idle_on ? $urandom_range(0, 11) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: check each send, then stall for a random number of cycles
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_sends.size() == 0) begin
                    report_mismatch($sformatf("unexpected send addr %0h payload %0h",
                                              o_out_data.send_address, o_out_data.send_payload));
                end else begin
                    want = expected_sends.pop_front();
                    if (o_out_data.send_address !== want.send_address)
                        report_mismatch($sformatf("send_address %0h, expected %0h",
                                                  o_out_data.send_address, want.send_address));
                    if (o_out_data.send_payload !== want.send_payload)
                        report_mismatch($sformatf("send_payload %0h, expected %0h",
                                                  o_out_data.send_payload, want.send_payload));
                end
                if ($urandom_range(0, 15) == 0)
                    recv_stall_on = !recv_stall_on;
                stall_left = recv_stall_on ? $urandom_range(0, 11) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    // Stimulus
    initial begin
        int          phase;
        int          n_items;
        int          random_items;
        int          reps;
        int          pick;
        logic [1:0]  k;
        logic [23:0] air;

        phase        = 0;
        random_items = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // Directed: zero interval, largest duty factor
        write_register(CFG_INITIAL_INTERVAL, 32'd0);
        write_register(CFG_DUTY_FACTOR, 32'd255);
        queue_item(KIND_PUSH, 8'h00, 8'h00, 24'h000000);
        queue_item(KIND_PUSH, 8'hFF, 8'hFF, 24'hFFFFFF);
        queue_item(KIND_PUSH, 8'hA5, 8'h5A, 24'h5A5A5A);
        queue_item(KIND_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom));
        queue_item(KIND_TICK, 8'h00, 8'h00, 24'h000000);   // releases the newest
        queue_item(KIND_TICK, 8'h00, 8'h00, 24'h000000);   // busy, held
        queue_item(KIND_FINISH, 8'h00, 8'h00, 24'h000000); // zero product
        queue_item(KIND_TICK, 8'hFF, 8'hFF, 24'hFFFFFF);
        queue_item(KIND_FINISH, 8'h00, 8'h00, 24'hFFFFFF); // largest product
        queue_item(KIND_TICK, 8'h00, 8'h00, 24'h000000);
        queue_item(KIND_FINISH, 8'h00, 8'h00, 24'h000001); // not busy
        queue_item(KIND_TICK, 8'h00, 8'h00, 24'h000000);
        wait_quiet();

        // Directed: zero duty factor, then drain to an empty store
        write_register(CFG_INITIAL_INTERVAL, 32'd0);
        write_register(CFG_DUTY_FACTOR, 32'd0);
        queue_item(KIND_PUSH, 8'h3C, 8'hC3, 24'h000000);
        queue_item(KIND_TICK, 8'h00, 8'h00, 24'h000000);
        queue_item(KIND_FINISH, 8'h00, 8'h00, 24'hFFFFFF);
        queue_item(KIND_TICK, 8'h00, 8'h00, 24'h000000);
        queue_item(KIND_FINISH, 8'h00, 8'h00, 24'h000001);
        queue_item(KIND_TICK, 8'h00, 8'h00, 24'h000000);   // empty store
        queue_item(KIND_TICK, 8'h00, 8'h00, 24'h000000);
        wait_quiet();

        // Random phases, each under its own register setting
        while ((random_items < 1000 || release_count < 48) && phase < 40) begin
            case (phase)
                0: begin
                    write_register(CFG_INITIAL_INTERVAL, 32'hFFFF_FFFF);
                    write_register(CFG_DUTY_FACTOR, 32'd255);
                end
                1: begin
                    write_register(CFG_INITIAL_INTERVAL, $urandom);
                    write_register(CFG_DUTY_FACTOR, 32'd1);
                end
                default: begin
                    write_register(CFG_INITIAL_INTERVAL, 32'($urandom_range(0, 12)));
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        write_register(CFG_DUTY_FACTOR, 32'd0);
                    else if (pick == 1)
                        write_register(CFG_DUTY_FACTOR, 32'd255);
                    else if (pick == 2)
                        write_register(CFG_DUTY_FACTOR, 32'd1);
                    else
                        write_register(CFG_DUTY_FACTOR, 32'($urandom_range(1, 255)));
                end
            endcase
            // indexes past the register list must be ignored
            if (phase == 2) begin
                write_register(CFG_SPARE_A, $urandom);
                write_register(CFG_SPARE_B, $urandom);
            end

            n_items = 0;
            while (n_items < 150) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    // pushes, ticks until a release is due, then the finished report
                    reps = $urandom_range(1, 3);
                    for (int i = 0; i < reps; i++)
                        queue_item(KIND_PUSH, 8'($urandom), 8'($urandom), 24'($urandom));
                    n_items += reps;
                    reps = $urandom_range(1, 16);
                    for (int i = 0; i < reps; i++)
                        queue_item(KIND_TICK, 8'($urandom), 8'($urandom), 24'($urandom));
                    n_items += reps;
                    queue_item(KIND_FINISH, 8'($urandom), 8'($urandom), short_airtime());
                    n_items++;
                end else if (pick == 7) begin
                    // burst that can overfill the store
                    reps = $urandom_range(30, 40);
                    for (int i = 0; i < reps; i++)
                        queue_item(KIND_PUSH, 8'($urandom), 8'($urandom), 24'($urandom));
                    n_items += reps;
                end else begin
                    // noise: any kind, any fields
                    k = 2'($urandom_range(0, 3));
                    if (k == KIND_FINISH && $urandom_range(0, 7) != 0)
                        air = short_airtime();
                    else
                        air = 24'($urandom);
                    queue_item(k, 8'($urandom), 8'($urandom), air);
                    if (k != KIND_UNUSED)
                        n_items++;
                end
            end
            random_items += n_items;
            wait_quiet();
            phase++;
        end

        if (expected_sends.size() != 0)
            report_mismatch($sformatf("%0d sends never arrived", expected_sends.size()));
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
